// File: rtl/sha1bs_pkg.sv
// Shared types, codes and round functions for the SHA-1 byte-stream hasher.
// Holds no logic of its own and depends on nothing else.
`default_nettype none

package sha1bs_pkg;

	// Operation codes on the input channel
	localparam logic [1:0] OP_ABSORB  = 2'd0;
	localparam logic [1:0] OP_FINISH  = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// Status codes on the output channel
	localparam logic STATUS_DIGEST = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 5;
	localparam int ROUNDS      = 80;

	// First padding byte
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_REJECT,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PM_MARK,
		PM_ZERO,
		PM_LEN
	} pad_mode_t;

	// Standard initial chaining value
	function automatic logic [31:0] init_word(input logic [2:0] idx);
		logic [31:0] w;
		case (idx)
			3'd0: w = 32'h67452301;
			3'd1: w = 32'hefcdab89;
			3'd2: w = 32'h98badcfe;
			3'd3: w = 32'h10325476;
			3'd4: w = 32'hc3d2e1f0;
			default: w = 32'h0;
		endcase
		return w;
	endfunction

	// Additive constant for round t
	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = 32'h5a827999;
		end else if (t < 7'd40) begin
			k = 32'h6ed9eba1;
		end else if (t < 7'd60) begin
			k = 32'h8f1bbcdc;
		end else begin
			k = 32'hca62c1d6;
		end
		return k;
	endfunction

	// Boolean function for round t
	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = ((c ^ d) & b) ^ d;
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (d & (b | c));
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sha1_byte_stream_hasher_core.sv
// SHA-1 byte-stream hasher: byte packing, padding, compression and digest readout.
// Depends on sha1bs_pkg for codes, state types and round functions.
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   operation[1:0], data_byte[7:0]
// output    out_valid / out_stall status, word_index[2:0], digest_word[31:0], last
//
// An absorbed byte leaves the block ready for the next one; the 64th byte of a block
// starts the compression: load the chaining words from their memory, run the rounds
// through the one round unit, add back into the chaining memory.
// The first finish pads one byte a cycle (plus compressions); every finish then reads
// the five digest words, one at a time, through the chaining memory port.
// Reset and restart rewrite the chaining memory with the initial value.
// One item is in work at a time; a beat held by out_stall delays later results only,
// absorbs carry on.
module sha1_byte_stream_hasher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [2:0]       word_index,
	output logic [31:0]      digest_word,
	output logic             last
);

	sha1bs_pkg::state_t    state_q, state_d;
	sha1bs_pkg::pad_mode_t pad_mode_q;

	logic [6:0]  cnt_q;
	logic [5:0]  pos_q;
	logic [5:0]  pos_nx;
	logic [63:0] len_q;
	logic        fin_q;
	logic        padding_q;
	logic [23:0] acc_q;
	logic [2:0]  emit_k_q;
	logic        emit_ph_q;

	logic [31:0] wv_q  [0:sha1bs_pkg::CHAIN_WORDS-1];
	logic [31:0] win_q [0:sha1bs_pkg::BLOCK_WORDS-1];

	// Block word memory and chaining value memory
	logic [31:0] bmem [0:sha1bs_pkg::BLOCK_WORDS-1];
	logic [31:0] cmem [0:sha1bs_pkg::CHAIN_WORDS-1];
	logic [31:0] bmem_rd_q;
	logic [31:0] cmem_rd_q;
	logic [3:0]  bmem_raddr;
	logic [2:0]  cmem_raddr;
	logic        cmem_we;
	logic [2:0]  cmem_waddr;
	logic [31:0] cmem_wdata;

	logic        out_valid_q;
	logic        status_q;
	logic [2:0]  word_index_q;
	logic [31:0] digest_q;
	logic        last_q;

	logic        in_accept;
	logic        out_free;
	logic        out_load;
	logic        absorb_en;
	logic        ext_absorb;
	logic [7:0]  absorb_byte;
	logic [7:0]  len_byte;
	logic [31:0] acc_word;
	logic [2:0]  wv_idx;
	logic [31:0] wt;
	logic [31:0] round_sum;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_nx    = pos_q + 6'd1;
	assign wv_idx    = 3'(cnt_q - 7'd1);
	assign len_byte  = 8'(len_q >> {~pos_q[2:0], 3'b000});
	assign acc_word  = {acc_q, absorb_byte};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha1bs_pkg::ST_INIT: begin
				if (cnt_q == 7'(sha1bs_pkg::CHAIN_WORDS - 1)) state_d = sha1bs_pkg::ST_IDLE;
			end
			sha1bs_pkg::ST_IDLE: begin
				if (in_accept) begin
					case (operation)
						sha1bs_pkg::OP_ABSORB: begin
							if (fin_q) begin
								state_d = sha1bs_pkg::ST_REJECT;
							end else if (pos_q == 6'd63) begin
								state_d = sha1bs_pkg::ST_LOAD;
							end
						end
						sha1bs_pkg::OP_FINISH: begin
							state_d = fin_q ? sha1bs_pkg::ST_EMIT : sha1bs_pkg::ST_PAD;
						end
						sha1bs_pkg::OP_RESTART: state_d = sha1bs_pkg::ST_INIT;
						default: state_d = sha1bs_pkg::ST_IDLE;
					endcase
				end
			end
			sha1bs_pkg::ST_REJECT: begin
				if (out_free) state_d = sha1bs_pkg::ST_IDLE;
			end
			sha1bs_pkg::ST_PAD: begin
				if (pos_q == 6'd63) state_d = sha1bs_pkg::ST_LOAD;
			end
			sha1bs_pkg::ST_LOAD: begin
				if (cnt_q == 7'(sha1bs_pkg::CHAIN_WORDS)) state_d = sha1bs_pkg::ST_ROUND;
			end
			sha1bs_pkg::ST_ROUND: begin
				if (cnt_q == 7'(sha1bs_pkg::ROUNDS - 1)) state_d = sha1bs_pkg::ST_ADD;
			end
			sha1bs_pkg::ST_ADD: begin
				if (cnt_q == 7'(sha1bs_pkg::CHAIN_WORDS)) begin
					if (padding_q) begin
						state_d = sha1bs_pkg::ST_PAD;
					end else if (fin_q) begin
						state_d = sha1bs_pkg::ST_EMIT;
					end else begin
						state_d = sha1bs_pkg::ST_IDLE;
					end
				end
			end
			sha1bs_pkg::ST_EMIT: begin
				if (emit_ph_q && out_free && emit_k_q == 3'(sha1bs_pkg::CHAIN_WORDS - 1)) begin
					state_d = sha1bs_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1bs_pkg::ST_INIT;
		endcase
	end

	// Datapath controls per state
	always_comb begin
		in_stall    = 1'b1;
		absorb_en   = 1'b0;
		ext_absorb  = 1'b0;
		absorb_byte = data_byte;
		bmem_raddr  = 4'd0;
		cmem_raddr  = 3'd0;
		cmem_we     = 1'b0;
		cmem_waddr  = 3'd0;
		cmem_wdata  = 32'h0;
		out_load    = 1'b0;
		case (state_q)
			sha1bs_pkg::ST_INIT: begin
				cmem_we    = 1'b1;
				cmem_waddr = cnt_q[2:0];
				cmem_wdata = sha1bs_pkg::init_word(cnt_q[2:0]);
			end
			sha1bs_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				ext_absorb = in_valid && operation == sha1bs_pkg::OP_ABSORB && !fin_q;
				absorb_en  = ext_absorb;
			end
			sha1bs_pkg::ST_REJECT: begin
				out_load = out_free;
			end
			sha1bs_pkg::ST_PAD: begin
				absorb_en = 1'b1;
				case (pad_mode_q)
					sha1bs_pkg::PM_MARK: absorb_byte = sha1bs_pkg::PAD_BYTE;
					sha1bs_pkg::PM_ZERO: absorb_byte = 8'h00;
					sha1bs_pkg::PM_LEN:  absorb_byte = len_byte;
					default:             absorb_byte = 8'h00;
				endcase
			end
			sha1bs_pkg::ST_LOAD: begin
				if (cnt_q < 7'(sha1bs_pkg::CHAIN_WORDS)) cmem_raddr = cnt_q[2:0];
			end
			sha1bs_pkg::ST_ROUND: begin
				bmem_raddr = cnt_q[3:0] + 4'd1;
			end
			sha1bs_pkg::ST_ADD: begin
				if (cnt_q < 7'(sha1bs_pkg::CHAIN_WORDS)) cmem_raddr = cnt_q[2:0];
				cmem_we    = cnt_q != 7'd0;
				cmem_waddr = wv_idx;
				cmem_wdata = cmem_rd_q + wv_q[wv_idx];
			end
			sha1bs_pkg::ST_EMIT: begin
				cmem_raddr = emit_k_q;
				out_load   = emit_ph_q && out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Round unit: schedule word and new working value
	always_comb begin
		if (cnt_q < 7'(sha1bs_pkg::BLOCK_WORDS)) begin
			wt = bmem_rd_q;
		end else begin
			wt = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
			wt = {wt[30:0], wt[31]};
		end
		round_sum = {wv_q[0][26:0], wv_q[0][31:27]}
			+ sha1bs_pkg::round_f(cnt_q, wv_q[1], wv_q[2], wv_q[3])
			+ wv_q[4] + wt + sha1bs_pkg::round_k(cnt_q);
	end

	// Memories: registered read, single write port each
	always_ff @(posedge clk) begin
		if (absorb_en && pos_q[1:0] == 2'b11) bmem[pos_q[5:2]] <= acc_word;
		bmem_rd_q <= bmem[bmem_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmem_we) cmem[cmem_waddr] <= cmem_wdata;
		cmem_rd_q <= cmem[cmem_raddr];
	end

	// Working variables, schedule window and partial word
	always_ff @(posedge clk) begin
		if (absorb_en) acc_q <= acc_word[23:0];
		if (state_q == sha1bs_pkg::ST_LOAD && cnt_q != 7'd0) begin
			wv_q[wv_idx] <= cmem_rd_q;
		end
		if (state_q == sha1bs_pkg::ST_ROUND) begin
			wv_q[0] <= round_sum;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
			for (int i = 0; i < sha1bs_pkg::BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha1bs_pkg::BLOCK_WORDS-1] <= wt;
		end
	end

	// Output register: load a beat when free, drop valid once taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == sha1bs_pkg::ST_REJECT) begin
				status_q     <= sha1bs_pkg::STATUS_REJECT;
				word_index_q <= 3'd0;
				digest_q     <= 32'h0;
				last_q       <= 1'b1;
			end else begin
				status_q     <= sha1bs_pkg::STATUS_DIGEST;
				word_index_q <= emit_k_q;
				digest_q     <= cmem_rd_q;
				last_q       <= emit_k_q == 3'(sha1bs_pkg::CHAIN_WORDS - 1);
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha1bs_pkg::ST_INIT;
			cnt_q       <= 7'd0;
			pos_q       <= 6'd0;
			len_q       <= 64'd0;
			fin_q       <= 1'b0;
			padding_q   <= 1'b0;
			pad_mode_q  <= sha1bs_pkg::PM_MARK;
			emit_k_q    <= 3'd0;
			emit_ph_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 7'd0 : cnt_q + 7'd1;

			if (absorb_en) pos_q <= pos_nx;
			if (ext_absorb) len_q <= len_q + 64'd8;

			// Restart clears message state; chaining words are rewritten in ST_INIT
			if (state_q == sha1bs_pkg::ST_IDLE && in_accept
					&& operation == sha1bs_pkg::OP_RESTART) begin
				pos_q     <= 6'd0;
				len_q     <= 64'd0;
				fin_q     <= 1'b0;
				padding_q <= 1'b0;
			end

			// Start padding on the first finish
			if (state_q == sha1bs_pkg::ST_IDLE && in_accept
					&& operation == sha1bs_pkg::OP_FINISH && !fin_q) begin
				padding_q  <= 1'b1;
				pad_mode_q <= sha1bs_pkg::PM_MARK;
			end

			// Advance the padding sequence
			if (state_q == sha1bs_pkg::ST_PAD) begin
				case (pad_mode_q)
					sha1bs_pkg::PM_MARK, sha1bs_pkg::PM_ZERO: begin
						pad_mode_q <= (pos_nx == 6'd56) ? sha1bs_pkg::PM_LEN
							: sha1bs_pkg::PM_ZERO;
					end
					sha1bs_pkg::PM_LEN: begin
						if (pos_q == 6'd63) begin
							fin_q     <= 1'b1;
							padding_q <= 1'b0;
						end
					end
					default: pad_mode_q <= sha1bs_pkg::PM_MARK;
				endcase
			end

			// Digest readout: wait for the registered read data, then hand over the beat
			if (state_q != sha1bs_pkg::ST_EMIT) begin
				emit_k_q  <= 3'd0;
				emit_ph_q <= 1'b0;
			end else if (!emit_ph_q) begin
				emit_ph_q <= 1'b1;
			end else if (out_free) begin
				emit_ph_q <= 1'b0;
				emit_k_q  <= emit_k_q + 3'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign word_index  = word_index_q;
	assign digest_word = digest_q;
	assign last        = last_q;

	// A compression only starts on a block boundary
	a_load_on_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bs_pkg::ST_LOAD && cnt_q == 7'd0) |-> pos_q == 6'd0)
		else $error("compression started off a block boundary");

	// Padding and the finished flag never overlap
	a_pad_fin_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(fin_q && padding_q))
		else $error("padding still active after finish");

	// Round counter stays within the round count
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha1bs_pkg::ST_ROUND |-> cnt_q < 7'(sha1bs_pkg::ROUNDS))
		else $error("round counter out of range");

	// A mid-padding compression returns to padding
	a_add_to_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bs_pkg::ST_ADD && cnt_q == 7'(sha1bs_pkg::CHAIN_WORDS) && padding_q)
		|=> state_q == sha1bs_pkg::ST_PAD)
		else $error("padding not resumed after compression");

	// Last marks either a reject or the final digest word
	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (status_q == sha1bs_pkg::STATUS_REJECT
			|| word_index_q == 3'(sha1bs_pkg::CHAIN_WORDS - 1)))
		else $error("last set on an inner digest word");

endmodule

`default_nettype wire

// File: sim/tb_sha1_byte_stream_hasher_core.sv
// Self-checking testbench for sha1_byte_stream_hasher_core: directed rows, then random messages.
// Carries its own SHA-1 digest predictor; needs only sha1bs_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher_core;

	localparam int CLK_PERIOD  = 8;
	localparam int ITEM_TARGET = 450;
	localparam int TAIL_CYCLES = 150;
	localparam int DRAIN_LIMIT = 20000;

	// Opcode the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Round constants
	localparam logic [31:0] K_CH   = 32'h5a827999;
	localparam logic [31:0] K_PAR1 = 32'h6ed9eba1;
	localparam logic [31:0] K_MAJ  = 32'h8f1bbcdc;
	localparam logic [31:0] K_PAR2 = 32'hca62c1d6;

	// Well-known digests, word 0 in the top bits
	localparam logic [159:0] EMPTY_DIGEST =
		160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] ABC_DIGEST =
		160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	typedef struct packed {
		logic        status;
		logic [2:0]  idx;
		logic [31:0] word;
		logic        last;
	} word_beat_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_REJECT,
		CHK_EMPTY,
		CHK_ABC
	} row_check_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		row_check_t chk;
	} stim_row_t;

	localparam int DIR_ROWS = 23;

	// Directed rows: empty message, rejects, ignored opcode, "abc", restarts
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{sha1bs_pkg::OP_FINISH,  8'h00, CHK_EMPTY},
		'{sha1bs_pkg::OP_FINISH,  8'hff, CHK_EMPTY},
		'{sha1bs_pkg::OP_ABSORB,  8'h00, CHK_REJECT},
		'{sha1bs_pkg::OP_ABSORB,  8'hff, CHK_REJECT},
		'{OP_UNUSED,              8'ha5, CHK_MODEL},
		'{sha1bs_pkg::OP_RESTART, 8'h5a, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'h61, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'h62, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'h63, CHK_MODEL},
		'{OP_UNUSED,              8'hff, CHK_MODEL},
		'{sha1bs_pkg::OP_FINISH,  8'h00, CHK_ABC},
		'{sha1bs_pkg::OP_FINISH,  8'h33, CHK_ABC},
		'{sha1bs_pkg::OP_ABSORB,  8'h80, CHK_REJECT},
		'{sha1bs_pkg::OP_RESTART, 8'h00, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'hff, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'h00, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'h80, CHK_MODEL},
		'{sha1bs_pkg::OP_ABSORB,  8'h7f, CHK_MODEL},
		'{sha1bs_pkg::OP_FINISH,  8'h00, CHK_MODEL},
		'{sha1bs_pkg::OP_RESTART, 8'hff, CHK_MODEL},
		'{sha1bs_pkg::OP_RESTART, 8'h00, CHK_MODEL},
		'{sha1bs_pkg::OP_FINISH,  8'h00, CHK_EMPTY},
		'{sha1bs_pkg::OP_RESTART, 8'h00, CHK_MODEL}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [2:0]  word_index;
	logic [31:0] digest_word;
	logic        last;

	// Predictor state
	logic [31:0] hv [sha1bs_pkg::CHAIN_WORDS];
	logic [31:0] blk [sha1bs_pkg::BLOCK_WORDS];
	logic [5:0]  pos;
	logic [63:0] nbits;
	logic        done;

	word_beat_t owed_words [$];
	word_beat_t step_words [$];
	int         beats_taken = 0;
	int         faults = 0;
	logic       quiet = 1'b0;

	sha1_byte_stream_hasher_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.word_index  (word_index),
		.digest_word (digest_word),
		.last        (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Reload the standard chaining value and clear the message state
	function automatic void sha1_restart();
		int i;
		hv[0] = 32'h67452301;
		hv[1] = 32'hefcdab89;
		hv[2] = 32'h98badcfe;
		hv[3] = 32'h10325476;
		hv[4] = 32'hc3d2e1f0;
		for (i = 0; i < sha1bs_pkg::BLOCK_WORDS; i++) blk[i] = 32'h0;
		pos   = 6'd0;
		nbits = 64'd0;
		done  = 1'b0;
	endfunction

	// Run 80 rounds over the current block and fold into the chaining value
	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int i;
		for (i = 0; i < 16; i++) w[i] = blk[i];
		for (i = 16; i < 80; i++) begin
			x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {x[30:0], x[31]};
		end
		a = hv[0];
		b = hv[1];
		c = hv[2];
		d = hv[3];
		e = hv[4];
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_PAR1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR2;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hv[0] += a;
		hv[1] += b;
		hv[2] += c;
		hv[3] += d;
		hv[4] += e;
	endfunction

	// Shift one byte into the block; compress on the 64th
	function automatic void sha1_absorb(input logic [7:0] v);
		blk[pos[5:2]] = {blk[pos[5:2]][23:0], v};
		pos = pos + 6'd1;
		if (pos == 6'd0) sha1_compress();
		nbits = nbits + 64'd8;
	endfunction

	// Marker byte, zero fill to byte 56, then the length captured up front
	function automatic void sha1_pad();
		logic [63:0] len;
		logic [63:0] sh;
		int i;
		len = nbits;
		sha1_absorb(sha1bs_pkg::PAD_BYTE);
		while (pos != 6'd56) sha1_absorb(8'h00);
		for (i = 0; i < 8; i++) begin
			sh = len >> (56 - 8 * i);
			sha1_absorb(sh[7:0]);
		end
		done = 1'b1;
	endfunction

	// Advance the predictor by one beat; results land in step_words
	function automatic void sha1_step(input logic [1:0] op, input logic [7:0] v);
		int i;
		step_words.delete();
		case (op)
			sha1bs_pkg::OP_ABSORB: begin
				if (done) begin
					step_words.push_back('{sha1bs_pkg::STATUS_REJECT, 3'd0, 32'd0, 1'b1});
				end else begin
					sha1_absorb(v);
				end
			end
			sha1bs_pkg::OP_FINISH: begin
				if (!done) sha1_pad();
				for (i = 0; i < sha1bs_pkg::CHAIN_WORDS; i++) begin
					step_words.push_back('{sha1bs_pkg::STATUS_DIGEST, 3'(i), hv[i],
						i == sha1bs_pkg::CHAIN_WORDS - 1});
				end
			end
			sha1bs_pkg::OP_RESTART: begin
				sha1_restart();
			end
			default: begin
			end
		endcase
	endfunction

	// Present one beat, hold it until taken, then book its expected results
	task automatic drive_item(input logic [1:0] op, input logic [7:0] v, input row_check_t chk);
		int i;
		int gap;
		logic [159:0] known;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			in_valid  <= 1'b0;
			operation <= 2'($urandom);
			data_byte <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		data_byte <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sha1_step(op, v);
		if (op != OP_UNUSED) beats_taken++;
		case (chk)
			CHK_MODEL: begin
				foreach (step_words[i]) owed_words.push_back(step_words[i]);
			end
			CHK_REJECT: begin
				owed_words.push_back('{sha1bs_pkg::STATUS_REJECT, 3'd0, 32'd0, 1'b1});
			end
			default: begin
				known = (chk == CHK_EMPTY) ? EMPTY_DIGEST : ABC_DIGEST;
				for (i = 0; i < sha1bs_pkg::CHAIN_WORDS; i++) begin
					owed_words.push_back('{sha1bs_pkg::STATUS_DIGEST, 3'(i),
						known[159 - 32 * i -: 32], i == sha1bs_pkg::CHAIN_WORDS - 1});
				end
			end
		endcase
	endtask

	// Hold off the sender until every owed result has been seen
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_words.size() != 0) @(posedge clk);
	endtask

	// Output stall in random runs; none once the run settles
	initial begin : stall_pattern
		int   run;
		logic hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			run  = $urandom_range(1, 9);
			hold = ($urandom_range(0, 2) == 0);
			repeat (run) begin
				@(negedge clk);
				out_stall <= hold && !quiet;
			end
		end
	end

	// Compare each taken result beat with the oldest expectation
	always @(posedge clk) begin
		word_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_words.size() == 0) begin
				$error("unexpected beat: status %0d index %0d word %h last %0d",
					status, word_index, digest_word, last);
				faults++;
			end else begin
				want = owed_words.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					faults++;
				end
				if (word_index !== want.idx) begin
					$error("word_index: expected %0d, got %0d", want.idx, word_index);
					faults++;
				end
				if (digest_word !== want.word) begin
					$error("digest_word: expected %h, got %h", want.word, digest_word);
					faults++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					faults++;
				end
			end
		end
	end

	// Hard stop
	initial begin : watchdog
		#(2000000 * CLK_PERIOD);
		$display("[sha1_byte_stream_hasher_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		int r;
		int i;
		int n;
		int guard;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = sha1bs_pkg::OP_ABSORB;
		data_byte = 8'h00;
		sha1_restart();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (r = 0; r < DIR_ROWS; r++) begin
			drive_item(dir_rows[r].op, dir_rows[r].data, dir_rows[r].chk);
		end
		drain_results();

		// Random messages, with boundary lengths around the padding split
		while (beats_taken < ITEM_TARGET) begin
			quiet = (beats_taken >= ITEM_TARGET * 85 / 100);
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 4) != 0) begin
					drive_item(sha1bs_pkg::OP_RESTART, 8'($urandom), CHK_MODEL);
				end
				case ($urandom_range(0, 3))
					0: begin
						case ($urandom_range(0, 5))
							0: n = 55;
							1: n = 56;
							2: n = 63;
							3: n = 64;
							4: n = $urandom_range(119, 121);
							default: n = $urandom_range(0, 1);
						endcase
					end
					default: n = $urandom_range(0, 30);
				endcase
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 19) == 0) drive_item(OP_UNUSED, 8'($urandom), CHK_MODEL);
					drive_item(sha1bs_pkg::OP_ABSORB, 8'($urandom), CHK_MODEL);
				end
				drive_item(sha1bs_pkg::OP_FINISH, 8'($urandom), CHK_MODEL);
				if ($urandom_range(0, 3) == 0) begin
					drive_item(sha1bs_pkg::OP_FINISH, 8'($urandom), CHK_MODEL);
				end
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						drive_item(sha1bs_pkg::OP_ABSORB, 8'($urandom), CHK_MODEL);
					end
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					drive_item(2'($urandom_range(0, 3)), 8'($urandom), CHK_MODEL);
				end
			end
			if (!quiet && $urandom_range(0, 5) == 0) drain_results();
		end

		// Wind down: wait for owed results, then let the block go quiet
		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (owed_words.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (owed_words.size() != 0) begin
			$error("%0d result beats never arrived", owed_words.size());
			faults++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0) begin
			$display("[sha1_byte_stream_hasher_core] OK");
		end else begin
			$display("[sha1_byte_stream_hasher_core] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/sha1bs_pkg.sv
rtl/sha1_byte_stream_hasher_core.sv
sim/tb_sha1_byte_stream_hasher_core.sv
